FILE: hw/rtl/rrb_pkg.sv
`default_nettype none
package rrb_pkg;

  // Field widths of the response and event words
  localparam int SEQ_W = 32;
  localparam int PAY_W = 16;
  localparam int EV_W  = 2;

  // Default number of reorder slots
  localparam int DEPTH_DEF = 16;

  // Event codes
  localparam logic [EV_W-1:0] EV_SEND   = 2'd0;
  localparam logic [EV_W-1:0] EV_CLOSE  = 2'd1;
  localparam logic [EV_W-1:0] EV_REJECT = 2'd2;

  // One result word as produced by the controller
  typedef struct packed {
    logic [EV_W-1:0]  event_res;
    logic [PAY_W-1:0] out_payload;
    logic [SEQ_W-1:0] out_seq;
    logic             last;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rrb_if.sv
`default_nettype none
// Response channel
interface rrb_in_if;
  logic                      valid;
  logic                      ready;
  logic [rrb_pkg::SEQ_W-1:0] seq_id;
  logic [rrb_pkg::PAY_W-1:0] payload;
  logic                      keep_conn;

  modport source (output valid, output seq_id, output payload, output keep_conn,
                  input ready);
  modport sink (input valid, input seq_id, input payload, input keep_conn,
                output ready);
endinterface

// Event channel
interface rrb_out_if;
  logic                      valid;
  logic                      ready;
  logic [rrb_pkg::EV_W-1:0]  event_res;
  logic [rrb_pkg::PAY_W-1:0] out_payload;
  logic [rrb_pkg::SEQ_W-1:0] out_seq;
  logic                      last;

  modport source (output valid, output event_res, output out_payload, output out_seq,
                  output last, input ready);
  modport sink (input valid, input event_res, input out_payload, input out_seq,
                input last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rrb_ram.sv
`default_nettype none
module rrb_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: hw/rtl/rrb_out_reg.sv
`default_nettype none
module rrb_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             emit_v,
  input  wire rrb_pkg::result_t emit_res,
  output logic                  out_free,
  rrb_out_if.source             out_evt
);

  logic             out_valid_r;
  logic             out_valid_nxt;
  rrb_pkg::result_t res_r;

  // Slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_evt.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_evt.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_v) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load a new word when the controller emits
  always_ff @(posedge clk) begin
    if (emit_v) begin
      res_r <= emit_res;
    end
  end

  assign out_evt.valid       = out_valid_r;
  assign out_evt.event_res   = res_r.event_res;
  assign out_evt.out_payload = res_r.out_payload;
  assign out_evt.out_seq     = res_r.out_seq;
  assign out_evt.last        = res_r.last;

endmodule
`default_nettype wire

FILE: hw/rtl/rrb_ctrl.sv
`default_nettype none
module rrb_ctrl #(
  parameter int DEPTH = rrb_pkg::DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // response side
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [rrb_pkg::SEQ_W-1:0] in_seq_id,
  input  wire logic [rrb_pkg::PAY_W-1:0] in_payload,
  input  wire logic                      in_keep_conn,
  // event side
  output logic                           emit_v,
  output rrb_pkg::result_t               emit_res,
  input  wire logic                      out_free,
  // slot memory
  output logic                           ram_we,
  output logic [$clog2(DEPTH)-1:0]       ram_waddr,
  output logic [rrb_pkg::PAY_W:0]        ram_wdata,
  output logic [$clog2(DEPTH)-1:0]       ram_raddr,
  input  wire logic [rrb_pkg::PAY_W:0]   ram_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = rrb_pkg::SEQ_W;
  localparam int PW = rrb_pkg::PAY_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_INS   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_CLOSE = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [SW-1:0] next_seq_r, next_seq_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [PW-1:0] pend_pay_r, pend_pay_nxt;
  logic [SW-1:0] pend_seq_r, pend_seq_nxt;
  logic [SW-1:0] seq_r;
  logic [PW-1:0] pay_r;
  logic          keep_r;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          fwd_hit_r;
  logic [PW:0]   fwd_data_r;

  logic [SW-1:0] win_off;
  logic          stale;
  logic          beyond;
  logic [AW:0]   isum;
  logic [AW-1:0] head_inc;
  logic [PW:0]   rd_word;
  logic          cur_v;

  // Bypass a write that hit the address read in the same cycle
  assign rd_word = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign cur_v   = rd_word[PW];

  // Window position of the held response
  assign win_off = seq_r - next_seq_r;
  assign stale   = seq_r < next_seq_r;
  assign beyond  = win_off >= SW'(DEPTH);
  assign isum    = {1'b0, head_r} + {1'b0, win_off[AW-1:0]};

  always_comb begin
    if (isum >= (AW+1)'(DEPTH)) begin
      idx_nxt = AW'(isum - (AW+1)'(DEPTH));
    end else begin
      idx_nxt = isum[AW-1:0];
    end
  end

  // Slot of the next expected number; restart at zero after the last slot or when the sequence counter wraps
  always_comb begin
    if (next_seq_r == '1 || head_r == LAST_IDX) begin
      head_inc = '0;
    end else begin
      head_inc = head_r + AW'(1);
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    next_seq_nxt = next_seq_r;
    head_nxt     = head_r;
    pend_v_nxt   = pend_v_r;
    pend_pay_nxt = pend_pay_r;
    pend_seq_nxt = pend_seq_r;
    emit_v       = 1'b0;
    emit_res     = '0;
    ram_we       = 1'b0;
    ram_waddr    = head_r;
    ram_wdata    = '0;
    ram_raddr    = head_r;

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ram_raddr = idx_nxt;
        if (stale) begin
          state_nxt = ST_IDLE;
        end else if (beyond) begin
          if (out_free) begin
            emit_v             = 1'b1;
            emit_res.event_res = rrb_pkg::EV_REJECT;
            emit_res.out_seq   = seq_r;
            emit_res.last      = 1'b1;
            state_nxt          = ST_IDLE;
          end
        end else begin
          state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        // Park the payload unless the slot already holds one; then fetch the head
        if (!cur_v) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          ram_wdata = {1'b1, pay_r};
        end
        ram_raddr  = head_r;
        pend_v_nxt = 1'b0;
        state_nxt  = ST_DRAIN;
      end
      ST_DRAIN: begin
        // Hold one send back until the following slot shows whether it is last
        if (pend_v_r && !out_free) begin
          ram_raddr = head_r;
        end else begin
          if (pend_v_r) begin
            emit_v               = 1'b1;
            emit_res.event_res   = rrb_pkg::EV_SEND;
            emit_res.out_payload = pend_pay_r;
            emit_res.out_seq     = pend_seq_r;
            emit_res.last        = keep_r && !cur_v;
          end
          if (cur_v) begin
            pend_v_nxt   = 1'b1;
            pend_pay_nxt = rd_word[PW-1:0];
            pend_seq_nxt = next_seq_r;
            ram_we       = 1'b1;
            ram_waddr    = head_r;
            ram_wdata    = '0;
            next_seq_nxt = next_seq_r + SW'(1);
            head_nxt     = head_inc;
            ram_raddr    = head_inc;
          end else begin
            pend_v_nxt = 1'b0;
            state_nxt  = keep_r ? ST_IDLE : ST_CLOSE;
          end
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          emit_v             = 1'b1;
          emit_res.event_res = rrb_pkg::EV_CLOSE;
          emit_res.out_seq   = seq_r;
          emit_res.last      = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      next_seq_r <= SW'(1);
      head_r     <= AW'(1);
      pend_v_r   <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      next_seq_r <= next_seq_nxt;
      head_r     <= head_nxt;
      pend_v_r   <= pend_v_nxt;
      fwd_hit_r  <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  // Data registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      seq_r  <= in_seq_id;
      pay_r  <= in_payload;
      keep_r <= in_keep_conn;
    end
    idx_r      <= idx_nxt;
    pend_pay_r <= pend_pay_nxt;
    pend_seq_r <= pend_seq_nxt;
    fwd_data_r <= ram_wdata;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/response_reorder_buffer_unit.sv
`default_nettype none
// Response reorder buffer: responses tagged with a sequence number arrive out of
// order, are parked in one of WINDOW_DEPTH slots of a single-port-write RAM, and
// leave as send events strictly in sequence order, followed by a close event when
// keep_conn is 0. Numbers already released are dropped silently; numbers at or
// beyond the window are answered with one reject event. After reset the block
// clears every RAM slot in turn and accepts no response until done.
// A response is checked against the window and, unless dropped or rejected,
// parked; the drain then reads, forwards and clears one slot per cycle through
// the RAM port while the event output has room. Downstream stalls hold the
// reject, drain and close; no new response is taken until the last one is done.
module response_reorder_buffer_unit #(
  parameter int WINDOW_DEPTH = rrb_pkg::DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rrb_in_if.sink    in_rsp,
  rrb_out_if.source out_evt
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int MW = rrb_pkg::PAY_W + 1;

  logic             emit_v;
  rrb_pkg::result_t emit_res;
  logic             out_free;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [MW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [MW-1:0]    ram_rdata;

  rrb_ctrl #(
    .DEPTH (WINDOW_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_rsp.valid),
    .in_ready     (in_rsp.ready),
    .in_seq_id    (in_rsp.seq_id),
    .in_payload   (in_rsp.payload),
    .in_keep_conn (in_rsp.keep_conn),
    .emit_v       (emit_v),
    .emit_res     (emit_res),
    .out_free     (out_free),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  rrb_ram #(
    .WIDTH (MW),
    .DEPTH (WINDOW_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rrb_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .emit_v   (emit_v),
    .emit_res (emit_res),
    .out_free (out_free),
    .out_evt  (out_evt)
  );

endmodule
`default_nettype wire
